// ----- hw/rtl/pse_pkg.sv -----
// ============================================================================
// pse_pkg
// Shared widths, register codes, coefficient bundle and saturation helpers
// for the point strain energy unit.
// ============================================================================
package pse_pkg;

    localparam int WORD_W     = 64;
    localparam int GRAD_W     = 32;
    localparam int VOL_W      = 32;
    localparam int STRAIN_W   = 42;
    localparam int STRESS_W   = 48;
    localparam int ENERGY_W   = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MODULUS_W  = 32;
    localparam int POISSON_W  = 15;
    localparam int KV_W       = 32;
    localparam int G_W        = 32;
    localparam int K_W        = 47;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_YOUNG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POISSON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KV      = 2'd2;

    localparam logic signed [WORD_W-1:0] ONE_Q24 = 64'sh0000_0000_0100_0000;

    // Material coefficients handed from the coefficient unit to the datapath
    typedef struct packed {
        logic [G_W-1:0]  g;
        logic [K_W-1:0]  ca;
        logic [K_W-1:0]  cb;
        logic [KV_W-1:0] kv;
    } coef_t;

    // Saturating 64-bit signed add
    function automatic logic signed [WORD_W-1:0] sat_add64(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
        begin
            return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end
        return s[WORD_W-1:0];
    endfunction

    // Clamp a 64-bit signed value into the 48-bit stress range
    function automatic logic signed [STRESS_W-1:0] sat48(
        input logic signed [WORD_W-1:0] v
    );
        if (v[WORD_W-1:STRESS_W-1] != {(WORD_W-STRESS_W+1){v[WORD_W-1]}})
        begin
            return v[WORD_W-1] ? {1'b1, {(STRESS_W-1){1'b0}}}
                               : {1'b0, {(STRESS_W-1){1'b1}}};
        end
        return v[STRESS_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/pse_mulsh.sv -----
// ============================================================================
// pse_mulsh
// Four-stage signed multiply, constant right shift with truncation toward
// zero, and saturation to a signed range of SAT_W bits.
// ============================================================================
module pse_mulsh #(
    parameter int SHIFT = 24,
    parameter int SAT_W = 64
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [pse_pkg::WORD_W-1:0]     x,
    input  logic signed [pse_pkg::WORD_W-1:0]     y,
    output logic signed [pse_pkg::WORD_W-1:0]     q
);

    localparam int W  = pse_pkg::WORD_W;
    localparam int HW = W / 2;
    localparam logic [W-1:0] LIM = (64'd1 << (SAT_W - 1)) - 64'd1;

    logic           neg1_reg, neg2_reg, neg3_reg;
    logic [W-1:0]   ax_reg, ay_reg;
    logic [W-1:0]   p0_reg, p1_reg, p2_reg, p3_reg;
    logic [2*W-1:0] prod_reg;
    logic [2*W-1:0] prod_next;
    logic [2*W-1:0] shifted;
    logic [W-1:0]   qlo;
    logic           sat;
    logic [W-1:0]   q_next;
    logic [W-1:0]   q_reg;

    // Stage 1: magnitudes and sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= x[W-1] ^ y[W-1];
            ax_reg   <= x[W-1] ? (~x + 64'd1) : x;
            ay_reg   <= y[W-1] ? (~y + 64'd1) : y;
        end
    end

    // Stage 2: four half-word partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg2_reg <= neg1_reg;
            p0_reg   <= ax_reg[HW-1:0] * ay_reg[HW-1:0];
            p1_reg   <= ax_reg[HW-1:0] * ay_reg[W-1:HW];
            p2_reg   <= ax_reg[W-1:HW] * ay_reg[HW-1:0];
            p3_reg   <= ax_reg[W-1:HW] * ay_reg[W-1:HW];
        end
    end

    // Stage 3: combine partial products into the full product
    assign prod_next = {{W{1'b0}}, p0_reg}
                     + {{HW{1'b0}}, p1_reg, {HW{1'b0}}}
                     + {{HW{1'b0}}, p2_reg, {HW{1'b0}}}
                     + {p3_reg, {W{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg3_reg <= neg2_reg;
            prod_reg <= prod_next;
        end
    end

    // Stage 4: shift, clamp, restore sign
    assign shifted = prod_reg >> SHIFT;
    assign sat     = |shifted[2*W-1:SAT_W-1];
    assign qlo     = shifted[W-1:0];

    always_comb
    begin
        if (sat)
        begin
            q_next = neg3_reg ? ~LIM : LIM;
        end
        else
        begin
            q_next = neg3_reg ? (~qlo + 64'd1) : qlo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ----- hw/rtl/pse_delay.sv -----
// ============================================================================
// pse_delay
// Enabled shift line that carries payload alongside the multiplier stages.
// ============================================================================
module pse_delay #(
    parameter int W     = 32,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [DEPTH];

    // Advance every tap together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ----- hw/rtl/pse_coef.sv -----
// ============================================================================
// pse_coef
// Configuration registers and the serial unit that derives the stress
// coefficients g, ca and cb by restoring division and shift-add multiply.
// ============================================================================
module pse_coef (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [pse_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pse_pkg::CFG_DATA_W-1:0]      cfg_data,
    output pse_pkg::coef_t                      coef,
    output logic                                busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_G,
        ST_DIV_K,
        ST_MUL_A,
        ST_MUL_B
    } state_t;

    localparam logic [5:0] DIV_LAST = 6'd47;
    localparam logic [5:0] MUL_LAST = 6'd16;

    state_t                             state_reg;
    logic [pse_pkg::MODULUS_W-1:0]      young_reg;
    logic [pse_pkg::POISSON_W-1:0]      poisson_reg;
    logic [pse_pkg::KV_W-1:0]           kv_reg;
    logic [5:0]                         cnt_reg;
    logic [47:0]                        acc_reg;
    logic [16:0]                        rem_reg;
    logic [16:0]                        den_reg;
    logic [pse_pkg::K_W-1:0]            k_reg;
    logic [16:0]                        mul_reg;
    logic [63:0]                        prod_reg;
    logic [pse_pkg::G_W-1:0]            g_reg;
    logic [pse_pkg::K_W-1:0]            ca_reg;
    logic [pse_pkg::K_W-1:0]            cb_reg;

    logic [17:0]                        rem_t;
    logic                               ge;
    logic [16:0]                        rem_next;
    logic [47:0]                        acc_next;
    logic [63:0]                        prod_next;
    logic                               restart;

    // One restoring-division step and one shift-add step
    always_comb
    begin
        rem_t     = {rem_reg, acc_reg[47]};
        ge        = rem_t >= {1'b0, den_reg};
        rem_next  = ge ? 17'(rem_t - {1'b0, den_reg}) : rem_t[16:0];
        acc_next  = {acc_reg[46:0], ge};
        prod_next = {prod_reg[62:0], 1'b0} + (mul_reg[16] ? {17'd0, k_reg} : 64'd0);
    end

    // A modulus or ratio write restarts the sequence
    assign restart = cfg_valid
                  && (cfg_index == pse_pkg::CFG_YOUNG || cfg_index == pse_pkg::CFG_POISSON);

    // Sequencer and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            young_reg   <= 32'd65536;
            poisson_reg <= 15'd19661;
            kv_reg      <= 32'd65536;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            rem_reg     <= '0;
            den_reg     <= '0;
            k_reg       <= '0;
            mul_reg     <= '0;
            prod_reg    <= '0;
            g_reg       <= '0;
            ca_reg      <= '0;
            cb_reg      <= '0;
        end
        else
        begin
            if (restart)
            begin
                state_reg <= ST_LOAD;
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                    end
                    ST_LOAD:
                    begin
                        acc_reg   <= {young_reg, 16'd0};
                        rem_reg   <= '0;
                        den_reg   <= 17'd65536 + {2'b00, poisson_reg};
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV_G;
                    end
                    ST_DIV_G:
                    begin
                        if (cnt_reg == DIV_LAST)
                        begin
                            g_reg     <= acc_next[pse_pkg::G_W-1:0];
                            acc_reg   <= {acc_next[pse_pkg::G_W-1:0], 16'd0};
                            rem_reg   <= '0;
                            den_reg   <= 17'd65536 - {1'b0, poisson_reg, 1'b0};
                            cnt_reg   <= '0;
                            state_reg <= ST_DIV_K;
                        end
                        else
                        begin
                            acc_reg <= acc_next;
                            rem_reg <= rem_next;
                            cnt_reg <= cnt_reg + 6'd1;
                        end
                    end
                    ST_DIV_K:
                    begin
                        if (cnt_reg == DIV_LAST)
                        begin
                            k_reg     <= acc_next[pse_pkg::K_W-1:0];
                            prod_reg  <= '0;
                            mul_reg   <= 17'd65536 - {2'b00, poisson_reg};
                            cnt_reg   <= '0;
                            state_reg <= ST_MUL_A;
                        end
                        else
                        begin
                            acc_reg <= acc_next;
                            rem_reg <= rem_next;
                            cnt_reg <= cnt_reg + 6'd1;
                        end
                    end
                    ST_MUL_A:
                    begin
                        if (cnt_reg == MUL_LAST)
                        begin
                            ca_reg    <= prod_next[62:16];
                            prod_reg  <= '0;
                            mul_reg   <= {2'b00, poisson_reg};
                            cnt_reg   <= '0;
                            state_reg <= ST_MUL_B;
                        end
                        else
                        begin
                            prod_reg <= prod_next;
                            mul_reg  <= {mul_reg[15:0], 1'b0};
                            cnt_reg  <= cnt_reg + 6'd1;
                        end
                    end
                    ST_MUL_B:
                    begin
                        if (cnt_reg == MUL_LAST)
                        begin
                            cb_reg    <= prod_next[62:16];
                            cnt_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            prod_reg <= prod_next;
                            mul_reg  <= {mul_reg[15:0], 1'b0};
                            cnt_reg  <= cnt_reg + 6'd1;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end

            // Register write
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pse_pkg::CFG_YOUNG:
                    begin
                        young_reg <= cfg_data;
                    end
                    pse_pkg::CFG_POISSON:
                    begin
                        poisson_reg <= cfg_data[pse_pkg::POISSON_W-1:0];
                    end
                    pse_pkg::CFG_KV:
                    begin
                        kv_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign coef.g  = g_reg;
    assign coef.ca = ca_reg;
    assign coef.cb = cb_reg;
    assign coef.kv = kv_reg;
    assign busy    = state_reg != ST_IDLE;

endmodule

// ----- hw/rtl/point_strain_energy_unit.sv -----
// Throughput: one point per cycle, set by the fully pipelined multipliers,
// while the skid entry is free and the coefficient unit is idle.
// An output register plus one skid entry let input continue while a result waits.
// After reset and after each modulus or ratio write, input is held off
// while the serial coefficient unit derives g, ca and cb.
// ============================================================================
// point_strain_energy_unit
// Green strain, linear isotropic stress and elastic plus volume energy of one
// point per transaction, in a 21-stage pipeline with a shared stall enable.
// ============================================================================
module point_strain_energy_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [pse_pkg::GRAD_W-1:0]       grad_00,
    input  logic signed [pse_pkg::GRAD_W-1:0]       grad_01,
    input  logic signed [pse_pkg::GRAD_W-1:0]       grad_02,
    input  logic signed [pse_pkg::GRAD_W-1:0]       grad_10,
    input  logic signed [pse_pkg::GRAD_W-1:0]       grad_11,
    input  logic signed [pse_pkg::GRAD_W-1:0]       grad_12,
    input  logic signed [pse_pkg::GRAD_W-1:0]       grad_20,
    input  logic signed [pse_pkg::GRAD_W-1:0]       grad_21,
    input  logic signed [pse_pkg::GRAD_W-1:0]       grad_22,
    input  logic [pse_pkg::VOL_W-1:0]               point_volume,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [pse_pkg::ENERGY_W-1:0]     energy,
    output logic signed [pse_pkg::STRESS_W-1:0]     stress_xx,
    output logic signed [pse_pkg::STRESS_W-1:0]     stress_yy,
    output logic signed [pse_pkg::STRESS_W-1:0]     stress_zz,
    output logic signed [pse_pkg::STRESS_W-1:0]     stress_xy,
    output logic signed [pse_pkg::STRESS_W-1:0]     stress_yz,
    output logic signed [pse_pkg::STRESS_W-1:0]     stress_zx,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pse_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [pse_pkg::CFG_DATA_W-1:0]          cfg_data
);

    localparam int W    = pse_pkg::WORD_W;
    localparam int SW   = pse_pkg::STRAIN_W;
    localparam int TW   = pse_pkg::STRESS_W;
    localparam int GW   = pse_pkg::GRAD_W;
    localparam int LAST = 20;

    typedef struct packed {
        logic [pse_pkg::ENERGY_W-1:0] energy;
        logic [5:0][TW-1:0]           stress;
    } res_t;

    logic              adv;
    logic              in_take;
    logic              coef_busy;
    pse_pkg::coef_t    coef;
    logic [LAST:0]     vld_reg;

    logic signed [W-1:0]  f [9];
    logic signed [W-1:0]  sp_q [18];
    logic signed [W-1:0]  ma_q [3];
    logic signed [W-1:0]  mb_q [3];
    logic signed [W-1:0]  e_sum [6];

    logic signed [SW-1:0] e_reg [6];
    logic signed [SW-1:0] others_reg [3];
    logic signed [W-1:0]  minor_reg [3];
    logic [3*GW-1:0]      f0_dly;
    logic signed [GW-1:0] f0_old [3];
    logic [pse_pkg::VOL_W-1:0] vol_dly;

    logic signed [W-1:0]  sa_q [3];
    logic signed [W-1:0]  sb_q [3];
    logic signed [W-1:0]  so_q [3];
    logic signed [W-1:0]  dt_q [3];
    logic [6*SW-1:0]      e_pack;
    logic [6*SW-1:0]      e_dly;
    logic signed [SW-1:0] e_old [6];

    logic signed [TW-1:0] s_reg [6];
    logic signed [W-1:0]  d_reg;
    logic [6*TW-1:0]      s_pack;
    logic [6*TW-1:0]      s_dly;

    logic signed [W-1:0]  ep_q [6];
    logic signed [W-1:0]  dsq_q;
    logic signed [W-1:0]  part_reg;
    logic signed [W-1:0]  hold_reg [3];
    logic signed [W-1:0]  dsq_a_reg;
    logic signed [W-1:0]  sum_reg;
    logic signed [W-1:0]  dsq_b_reg;
    logic signed [W-1:0]  ev_q;
    logic signed [W-1:0]  ek_q;
    logic signed [W-1:0]  energy_reg;

    res_t  pipe_res;
    res_t  out_reg;
    res_t  skid_reg;
    logic  pipe_v;
    logic  out_valid_reg;
    logic  skid_valid_reg;

    // Coefficients and configuration registers
    pse_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .busy      (coef_busy)
    );

    assign cfg_ready = 1'b1;

    // Pipeline moves whenever the skid entry is free
    assign adv      = !skid_valid_reg;
    assign in_ready = adv && !coef_busy;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], in_take};
        end
    end

    assign f[0] = 64'(grad_00);
    assign f[1] = 64'(grad_01);
    assign f[2] = 64'(grad_02);
    assign f[3] = 64'(grad_10);
    assign f[4] = 64'(grad_11);
    assign f[5] = 64'(grad_12);
    assign f[6] = 64'(grad_20);
    assign f[7] = 64'(grad_21);
    assign f[8] = 64'(grad_22);

    // Stage 0-3: column products for strain, row 1/2 products for minors
    genvar j, i, c;
    generate
        for (j = 0; j < 6; j++)
        begin : g_strain
            for (i = 0; i < 3; i++)
            begin : g_term
                pse_mulsh #(.SHIFT(24), .SAT_W(64)) u_sp (
                    .clk (clk),
                    .en  (adv),
                    .x   (f[i*3 + (j % 3)]),
                    .y   (f[i*3 + ((j < 3) ? j : ((j + 1) % 3))]),
                    .q   (sp_q[j*3 + i])
                );
            end
        end

        for (c = 0; c < 3; c++)
        begin : g_minor
            pse_mulsh #(.SHIFT(24), .SAT_W(64)) u_ma (
                .clk (clk),
                .en  (adv),
                .x   (f[3 + ((c + 1) % 3)]),
                .y   (f[6 + ((c + 2) % 3)]),
                .q   (ma_q[c])
            );
            pse_mulsh #(.SHIFT(24), .SAT_W(64)) u_mb (
                .clk (clk),
                .en  (adv),
                .x   (f[3 + ((c + 2) % 3)]),
                .y   (f[6 + ((c + 1) % 3)]),
                .q   (mb_q[c])
            );
        end
    endgenerate

    pse_delay #(.W(3*GW), .DEPTH(5)) u_f0_dly (
        .clk (clk),
        .en  (adv),
        .d   ({grad_02, grad_01, grad_00}),
        .q   (f0_dly)
    );

    pse_delay #(.W(pse_pkg::VOL_W), .DEPTH(16)) u_vol_dly (
        .clk (clk),
        .en  (adv),
        .d   (point_volume),
        .q   (vol_dly)
    );

    // Stage 4: strain entries, diagonal pair sums, minors
    generate
        for (j = 0; j < 6; j++)
        begin : g_esum
            assign e_sum[j] = sp_q[j*3] + sp_q[j*3 + 1] + sp_q[j*3 + 2]
                            - ((j < 3) ? pse_pkg::ONE_Q24 : 64'sd0);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    e_reg[j] <= e_sum[j][SW-1:0];
                end
            end

            assign e_pack[j*SW +: SW] = e_reg[j];
            assign e_old[j]           = e_dly[j*SW +: SW];
        end

        for (c = 0; c < 3; c++)
        begin : g_c1
            logic signed [W-1:0] pair_sum;
            assign pair_sum = e_sum[(c + 1) % 3] + e_sum[(c + 2) % 3];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    others_reg[c] <= pair_sum[SW-1:0];
                    minor_reg[c]  <= ma_q[c] - mb_q[c];
                end
            end

            assign f0_old[c] = f0_dly[c*GW +: GW];
        end
    endgenerate

    // Stage 5-8: stress products and determinant terms
    generate
        for (c = 0; c < 3; c++)
        begin : g_stress
            pse_mulsh #(.SHIFT(16), .SAT_W(TW)) u_sa (
                .clk (clk),
                .en  (adv),
                .x   (64'(e_reg[c])),
                .y   ({{(W - pse_pkg::K_W){1'b0}}, coef.ca}),
                .q   (sa_q[c])
            );
            pse_mulsh #(.SHIFT(16), .SAT_W(TW)) u_sb (
                .clk (clk),
                .en  (adv),
                .x   (64'(others_reg[c])),
                .y   ({{(W - pse_pkg::K_W){1'b0}}, coef.cb}),
                .q   (sb_q[c])
            );
            pse_mulsh #(.SHIFT(16), .SAT_W(TW)) u_so (
                .clk (clk),
                .en  (adv),
                .x   (64'(e_reg[c + 3])),
                .y   ({{(W - pse_pkg::G_W){1'b0}}, coef.g}),
                .q   (so_q[c])
            );
            pse_mulsh #(.SHIFT(24), .SAT_W(64)) u_dt (
                .clk (clk),
                .en  (adv),
                .x   (64'(f0_old[c])),
                .y   (minor_reg[c]),
                .q   (dt_q[c])
            );
        end
    endgenerate

    pse_delay #(.W(6*SW), .DEPTH(5)) u_e_dly (
        .clk (clk),
        .en  (adv),
        .d   (e_pack),
        .q   (e_dly)
    );

    // Stage 9: stresses and det - 1
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                s_reg[r]     <= pse_pkg::sat48(sa_q[r] + sb_q[r]);
                s_reg[r + 3] <= so_q[r][TW-1:0];
            end
            d_reg <= dt_q[0] + dt_q[1] + dt_q[2] - pse_pkg::ONE_Q24;
        end
    end

    // Stage 10-13: stress times strain, squared volume error
    generate
        for (j = 0; j < 6; j++)
        begin : g_work
            assign s_pack[j*TW +: TW] = s_reg[j];

            pse_mulsh #(.SHIFT((j < 3) ? 24 : 23), .SAT_W(64)) u_ep (
                .clk (clk),
                .en  (adv),
                .x   (64'(s_reg[j])),
                .y   (64'(e_old[j])),
                .q   (ep_q[j])
            );
        end
    endgenerate

    pse_mulsh #(.SHIFT(24), .SAT_W(64)) u_dsq (
        .clk (clk),
        .en  (adv),
        .x   (d_reg),
        .y   (d_reg),
        .q   (dsq_q)
    );

    pse_delay #(.W(6*TW), .DEPTH(11)) u_s_dly (
        .clk (clk),
        .en  (adv),
        .d   (s_pack),
        .q   (s_dly)
    );

    // Stage 14-15: saturating sum in row order xx, xy, yy, yz, zz, zx
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            part_reg    <= pse_pkg::sat_add64(pse_pkg::sat_add64(ep_q[0], ep_q[3]), ep_q[1]);
            hold_reg[0] <= ep_q[4];
            hold_reg[1] <= ep_q[2];
            hold_reg[2] <= ep_q[5];
            dsq_a_reg   <= dsq_q;
            sum_reg     <= pse_pkg::sat_add64(
                               pse_pkg::sat_add64(
                                   pse_pkg::sat_add64(part_reg, hold_reg[0]),
                                   hold_reg[1]),
                               hold_reg[2]);
            dsq_b_reg   <= dsq_a_reg;
        end
    end

    // Stage 16-19: scale by volume and by volume stiffness
    pse_mulsh #(.SHIFT(25), .SAT_W(64)) u_ev (
        .clk (clk),
        .en  (adv),
        .x   (sum_reg),
        .y   ({{(W - pse_pkg::VOL_W){1'b0}}, vol_dly}),
        .q   (ev_q)
    );

    pse_mulsh #(.SHIFT(17), .SAT_W(64)) u_ek (
        .clk (clk),
        .en  (adv),
        .x   (dsq_b_reg),
        .y   ({{(W - pse_pkg::KV_W){1'b0}}, coef.kv}),
        .q   (ek_q)
    );

    // Stage 20: total energy
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            energy_reg <= pse_pkg::sat_add64(ev_q, ek_q);
        end
    end

    assign pipe_v          = vld_reg[LAST];
    assign pipe_res.energy = energy_reg;
    assign pipe_res.stress = s_dly;

    // Output register and skid entry: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_v;
            end
        end
        else if (pipe_v && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid entry: data
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : pipe_res;
        end
        else if (!skid_valid_reg)
        begin
            skid_reg <= pipe_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign energy    = out_reg.energy;
    assign stress_xx = out_reg.stress[0];
    assign stress_yy = out_reg.stress[1];
    assign stress_zz = out_reg.stress[2];
    assign stress_xy = out_reg.stress[3];
    assign stress_yz = out_reg.stress[4];
    assign stress_zx = out_reg.stress[5];

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for point_strain_energy_unit: random and directed
// deformation gradients under several material settings, each result
// compared field by field against a fixed-point strain energy predictor.
// ============================================================================
module tb_top;

    localparam logic [pse_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  CYCLE_LIMIT  = 600000;
    localparam longint S48_TOP   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint I64_TOP   = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [pse_pkg::GRAD_W-1:0] f [9];
        logic [pse_pkg::VOL_W-1:0]         vol;
    } point_t;

    typedef struct {
        logic signed [pse_pkg::ENERGY_W-1:0] en;
        logic signed [pse_pkg::STRESS_W-1:0] s [6];
    } stress_energy_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
    logic signed [pse_pkg::GRAD_W-1:0] grad_00, grad_01, grad_02, grad_10, grad_11;
    logic signed [pse_pkg::GRAD_W-1:0] grad_12, grad_20, grad_21, grad_22;
    logic [pse_pkg::VOL_W-1:0] point_volume;
    logic signed [pse_pkg::ENERGY_W-1:0] energy;
    logic signed [pse_pkg::STRESS_W-1:0] stress_xx, stress_yy, stress_zz;
    logic signed [pse_pkg::STRESS_W-1:0] stress_xy, stress_yz, stress_zx;
    logic [pse_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pse_pkg::CFG_DATA_W-1:0] cfg_data;

    point_t         points_to_send [$];
    stress_energy_t expected_results [$];
    point_t         cur_point;

    // material copy seen by the predictor
    logic [pse_pkg::MODULUS_W-1:0] mat_young;
    logic [pse_pkg::POISSON_W-1:0] mat_poisson;
    logic [pse_pkg::KV_W-1:0]      mat_kv;

    bit     idling_on = 1'b1;
    int     err_count = 0;
    int     cycle_count = 0;
    int     in_gap = 0;
    int     out_stall = 0;

    point_strain_energy_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .grad_00(grad_00), .grad_01(grad_01), .grad_02(grad_02),
        .grad_10(grad_10), .grad_11(grad_11), .grad_12(grad_12),
        .grad_20(grad_20), .grad_21(grad_21), .grad_22(grad_22),
        .point_volume(point_volume),
        .out_valid(out_valid), .out_ready(out_ready),
        .energy(energy),
        .stress_xx(stress_xx), .stress_yy(stress_yy), .stress_zz(stress_zz),
        .stress_xy(stress_xy), .stress_yz(stress_yz), .stress_zx(stress_zx),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // trunc(x*y / 2^sh), clamped to [-lim-1, lim]
    function automatic longint scaled_mul(longint x, longint y, int sh, longint lim);
        logic [63:0]  ux, uy;
        logic [127:0] q;
        bit           neg;
        neg = (x < 0) != (y < 0);
        ux  = (x < 0) ? 64'(-x) : 64'(x);
        uy  = (y < 0) ? 64'(-y) : 64'(y);
        q   = ({64'b0, ux} * {64'b0, uy}) >> sh;
        if (q > {64'b0, lim})
        begin
            return neg ? -lim - 1 : lim;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint add_sat64(longint a, longint b);
        if (b > 0 && a > I64_TOP - b)
            return I64_TOP;
        if (b < 0 && a < -I64_TOP - 1 - b)
            return -I64_TOP - 1;
        return a + b;
    endfunction

    function automatic longint clamp48(longint v);
        if (v > S48_TOP)
            return S48_TOP;
        if (v < -S48_TOP - 1)
            return -S48_TOP - 1;
        return v;
    endfunction

    // Green strain, isotropic stress and energy of one point
    function automatic stress_energy_t predict_point(point_t p);
        stress_energy_t r;
        longint f [3][3];
        longint e [3][3];
        longint s [3][3];
        longint unsigned nu, g, k;
        longint ca, cb, sum, det, minor_v, d, dsq, en;
        int c1, c2;
        nu = mat_poisson;
        g  = ({32'b0, mat_young} << 16) / (65536 + nu);
        k  = (g << 16) / (65536 - 2 * nu);
        ca = longint'((k * (65536 - nu)) >> 16);
        cb = longint'((k * nu) >> 16);
        for (int i = 0; i < 9; i++)
            f[i / 3][i % 3] = longint'(p.f[i]);
        for (int rr = 0; rr < 3; rr++)
            for (int cc = 0; cc < 3; cc++)
            begin
                e[rr][cc] = (rr == cc) ? -longint'(pse_pkg::ONE_Q24) : 0;
                for (int i = 0; i < 3; i++)
                    e[rr][cc] += scaled_mul(f[i][rr], f[i][cc], 24, I64_TOP);
            end
        for (int rr = 0; rr < 3; rr++)
        begin
            s[rr][rr] = clamp48(
                scaled_mul(e[rr][rr], ca, 16, S48_TOP)
                + scaled_mul(e[(rr + 1) % 3][(rr + 1) % 3] + e[(rr + 2) % 3][(rr + 2) % 3],
                             cb, 16, S48_TOP));
            for (int cc = 0; cc < 3; cc++)
                if (cc != rr)
                    s[rr][cc] = scaled_mul(e[rr][cc], longint'(g), 16, S48_TOP);
        end
        sum = 0;
        for (int rr = 0; rr < 3; rr++)
        begin
            sum = add_sat64(sum, scaled_mul(s[rr][rr], e[rr][rr], 24, I64_TOP));
            sum = add_sat64(sum, scaled_mul(s[rr][(rr + 1) % 3], e[rr][(rr + 1) % 3],
                                            23, I64_TOP));
        end
        en  = scaled_mul(sum, longint'({32'b0, p.vol}), 25, I64_TOP);
        det = 0;
        for (int cc = 0; cc < 3; cc++)
        begin
            c1 = (cc + 1) % 3;
            c2 = (cc + 2) % 3;
            minor_v = scaled_mul(f[1][c1], f[2][c2], 24, I64_TOP)
                    - scaled_mul(f[1][c2], f[2][c1], 24, I64_TOP);
            det += scaled_mul(f[0][cc], minor_v, 24, I64_TOP);
        end
        d   = det - longint'(pse_pkg::ONE_Q24);
        dsq = scaled_mul(d, d, 24, I64_TOP);
        en  = add_sat64(en, scaled_mul(dsq, longint'({32'b0, mat_kv}), 17, I64_TOP));
        r.en   = en;
        r.s[0] = s[0][0][pse_pkg::STRESS_W-1:0];
        r.s[1] = s[1][1][pse_pkg::STRESS_W-1:0];
        r.s[2] = s[2][2][pse_pkg::STRESS_W-1:0];
        r.s[3] = s[0][1][pse_pkg::STRESS_W-1:0];
        r.s[4] = s[1][2][pse_pkg::STRESS_W-1:0];
        r.s[5] = s[2][0][pse_pkg::STRESS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    // Drive input transactions from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        stress_energy_t pred;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            grad_00      <= '0; grad_01 <= '0; grad_02 <= '0;
            grad_10      <= '0; grad_11 <= '0; grad_12 <= '0;
            grad_20      <= '0; grad_21 <= '0; grad_22 <= '0;
            point_volume <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pred = predict_point(cur_point);
                expected_results = {expected_results, pred};
            end
            if (!(in_valid && !in_ready))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (points_to_send.size() > 0)
                begin
                    cur_point = points_to_send.pop_front();
                    grad_00 <= cur_point.f[0]; grad_01 <= cur_point.f[1];
                    grad_02 <= cur_point.f[2]; grad_10 <= cur_point.f[3];
                    grad_11 <= cur_point.f[4]; grad_12 <= cur_point.f[5];
                    grad_20 <= cur_point.f[6]; grad_21 <= cur_point.f[7];
                    grad_22 <= cur_point.f[8];
                    point_volume <= cur_point.vol;
                    in_valid <= 1'b1;
                    if (idling_on && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 15);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Check result transactions and stall the output at random
    always @(posedge clk or negedge rst_n)
    begin
        stress_energy_t want;
        logic signed [pse_pkg::STRESS_W-1:0] got_s [6];
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                got_s = '{stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_zx};
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", energy, 64'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (energy !== want.en)
                        report_mismatch("energy", energy, want.en);
                    for (int i = 0; i < 6; i++)
                        if (got_s[i] !== want.s[i])
                            report_mismatch($sformatf("stress[%0d]", i),
                                            64'(got_s[i]), 64'(want.s[i]));
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 6) == 0)
                    out_stall = $urandom_range(1, 15);
            end
        end
    end

    // Track the material registers as the block accepts writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_young   <= 32'd65536;
            mat_poisson <= 15'd19661;
            mat_kv      <= 32'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pse_pkg::CFG_YOUNG:   mat_young   <= cfg_data;
                pse_pkg::CFG_POISSON: mat_poisson <= cfg_data[pse_pkg::POISSON_W-1:0];
                pse_pkg::CFG_KV:      mat_kv      <= cfg_data;
                default:              ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [pse_pkg::CFG_IDX_W-1:0] idx,
                             logic [pse_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every point is through, then let the pipe drain
    task automatic wait_drained();
        do
            @(posedge clk);
        while (points_to_send.size() > 0 || in_valid || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_grad(bit diag, int mode);
        case (mode)
            0: return (diag ? 32'h0100_0000 : 32'h0) + 32'($signed($urandom_range(0, 1 << 22))
                      - (1 << 21));
            1: return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_point(logic [31:0] a [9], logic [31:0] v);
        point_t p;
        for (int i = 0; i < 9; i++)
            p.f[i] = a[i];
        p.vol = v;
        points_to_send = {points_to_send, p};
    endtask

    task automatic add_random_points(int n);
        logic [31:0] a [9];
        logic [31:0] v;
        int mode;
        for (int j = 0; j < n; j++)
        begin
            mode = $urandom_range(0, 9);
            mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
            for (int i = 0; i < 9; i++)
                a[i] = ($urandom_range(0, 15) == 0) ? pick_grad(i % 4 == 0, 3)
                                                    : pick_grad(i % 4 == 0, mode);
            case ($urandom_range(0, 5))
                0: v = 32'hFFFF_FFFF;
                1: v = 32'h0;
                2: v = $urandom;
                default: v = $urandom_range(0, 32'h0400_0000);
            endcase
            add_point(a, v);
        end
    endtask

    task automatic add_directed_points();
        logic [31:0] a [9];
        logic [31:0] ident [9];
        ident = '{32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000};
        add_point(ident, 32'h0100_0000);
        a = '{default: 32'h0};
        add_point(a, 32'h0100_0000);
        a = '{default: 32'h7FFF_FFFF};
        add_point(a, 32'hFFFF_FFFF);
        a = '{default: 32'h8000_0000};
        add_point(a, 32'hFFFF_FFFF);
        a = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        add_point(a, 32'h0);
        a = '{32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000};
        add_point(a, 32'hFFFF_FFFF);
        // stretch along x, shear in xy, rotation about z
        a = ident; a[0] = 32'h0200_0000;
        add_point(a, 32'h0100_0000);
        a = ident; a[1] = 32'h0080_0000;
        add_point(a, 32'h0300_0000);
        a = '{0, 32'hFF00_0000, 0, 32'h0100_0000, 0, 0, 0, 0, 32'h0100_0000};
        add_point(a, 32'h0100_0000);
        a = '{default: 32'hFFFF_FFFF};
        add_point(a, 32'h0000_0001);
        a = '{default: 32'h0000_0001};
        add_point(a, 32'hFFFF_FFFF);
        a = '{default: 32'h5555_5555};
        add_point(a, 32'hAAAA_AAAA);
        a = '{default: 32'hAAAA_AAAA};
        add_point(a, 32'h5555_5555);
    endtask

    initial
    begin
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset material
        add_directed_points();
        add_random_points(250);
        wait_drained();

        // stiffest material, ratio at its top
        write_reg(pse_pkg::CFG_YOUNG, 32'hFFFF_FFFF);
        write_reg(pse_pkg::CFG_POISSON, 32'h0000_7FFF);
        write_reg(pse_pkg::CFG_KV, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        add_directed_points();
        add_random_points(250);
        wait_drained();

        // zero modulus, zero ratio, zero volume stiffness
        write_reg(pse_pkg::CFG_YOUNG, 32'h0);
        write_reg(pse_pkg::CFG_POISSON, 32'h0);
        write_reg(pse_pkg::CFG_KV, 32'h0);
        add_random_points(150);
        wait_drained();

        // smallest legal values
        write_reg(pse_pkg::CFG_YOUNG, 32'h1);
        write_reg(pse_pkg::CFG_POISSON, 32'h1);
        add_directed_points();
        add_random_points(150);
        wait_drained();

        // a few random materials
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(pse_pkg::CFG_YOUNG, $urandom);
            write_reg(pse_pkg::CFG_POISSON, $urandom);
            write_reg(pse_pkg::CFG_KV, $urandom);
            add_random_points(150);
            wait_drained();
        end

        // last stretch runs back to back
        write_reg(pse_pkg::CFG_YOUNG, 32'h0064_0000);
        write_reg(pse_pkg::CFG_POISSON, 32'd16384);
        idling_on = 1'b0;
        add_random_points(200);
        wait_drained();

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
